FILE: hdl/shqp_pkg.sv
`default_nettype none
package shqp_pkg;

  localparam int TABLE_SLOTS = 1024;
  localparam int SLOT_W      = $clog2(TABLE_SLOTS);
  localparam int M_W         = 11;
  localparam int VAL_W       = 16;
  localparam int CNT_W       = $clog2(VAL_W);
  localparam int HASH_MUL    = 37;
  localparam logic [M_W-1:0] M_RESET = 11'd1021;
  localparam logic [M_W-1:0] M_MIN   = 11'd2;
  localparam logic [M_W-1:0] M_MAX   = M_W'(TABLE_SLOTS);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_PROBE_RD,
    ST_PROBE_CHK
  } state_t;

  typedef struct packed {
    logic             go;
    logic [VAL_W-1:0] value;
    logic [M_W-1:0]   modulus;
  } mod_req_t;

endpackage
`default_nettype wire

FILE: hdl/shqp_mod_unit.sv
`default_nettype none
module shqp_mod_unit (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire shqp_pkg::mod_req_t     req,
  output logic                        done,
  output logic [shqp_pkg::SLOT_W-1:0] rem
);
  import shqp_pkg::*;

  logic             active;
  logic [CNT_W-1:0] cnt;
  logic [VAL_W-1:0] shreg;
  logic [M_W-1:0]   m;
  logic [M_W-1:0]   trial;
  logic [SLOT_W-1:0] rem_next;

  // restoring remainder, one dividend bit per cycle, MSB first
  always_comb begin
    trial = {rem, shreg[VAL_W-1]};
    if (trial >= m) begin
      rem_next = SLOT_W'(trial - m);
    end else begin
      rem_next = SLOT_W'(trial);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (req.go) begin
        active <= 1'b1;
        cnt    <= CNT_W'(VAL_W - 1);
      end else if (active) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.go) begin
      shreg <= req.value;
      m     <= req.modulus;
      rem   <= '0;
    end else if (active) begin
      shreg <= {shreg[VAL_W-2:0], 1'b0};
      rem   <= rem_next;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/string_hash_quadratic_probe_insert_top.sv
`default_nettype none
// Hashes a key one character per item (h = (h*37 + c) mod M) and, on the
// character marked last, inserts it into a 1024-entry occupancy table by
// quadratic probing, returning the slot and a placed flag on a one-cycle
// done strobe; the receiver cannot stall, so done must be sampled when it
// fires. M is the table_size register clamped to 2..1024, written through
// cfg_we/cfg_data; the user writes it only while busy is low, as the block
// itself does not enforce that. An item is taken when start is high and
// busy is low. After reset the block clears the table with busy high.
// Each character passes the shared bit-serial mod unit (one bit per cycle of
// the 16-bit h*37+c); a last character makes 1 to M probes (read, check).
module string_hash_quadratic_probe_insert_top (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [7:0]                    key_char,
  input  wire logic                          last_char,
  input  wire logic                          cfg_we,
  input  wire logic [shqp_pkg::M_W-1:0]      cfg_data,
  output logic                               done,
  output logic [shqp_pkg::SLOT_W-1:0]        slot,
  output logic                               placed
);
  import shqp_pkg::*;

  state_t state, state_next;

  logic [M_W-1:0]    table_size;
  logic [M_W-1:0]    m_eff;
  logic [SLOT_W-1:0] hash, hash_next;
  logic              last, last_next;
  logic [SLOT_W-1:0] loc, loc_next;
  logic [SLOT_W-1:0] step, step_next;
  logic [SLOT_W-1:0] probe_cnt, probe_cnt_next;
  logic [SLOT_W-1:0] clr_cnt, clr_cnt_next;
  logic              done_next, placed_next;
  logic [SLOT_W-1:0] slot_next;

  logic              slot_used [TABLE_SLOTS];
  logic              rd_used;
  logic              mem_we;
  logic [SLOT_W-1:0] mem_waddr;
  logic              mem_wdata;

  mod_req_t          mreq;
  logic              mod_done;
  logic [SLOT_W-1:0] mod_rem;

  function automatic logic [SLOT_W-1:0] add_mod(input logic [SLOT_W-1:0] a,
                                                input logic [SLOT_W-1:0] b,
                                                input logic [M_W-1:0] m);
    logic [M_W-1:0] s;
    s = M_W'(a) + M_W'(b);
    if (s >= m) begin
      s = s - m;
    end
    return SLOT_W'(s);
  endfunction

  always_comb begin
    if (table_size < M_MIN) begin
      m_eff = M_MIN;
    end else if (table_size > M_MAX) begin
      m_eff = M_MAX;
    end else begin
      m_eff = table_size;
    end
  end

  shqp_mod_unit u_mod (
    .clk  (clk),
    .rst  (rst),
    .req  (mreq),
    .done (mod_done),
    .rem  (mod_rem)
  );

  assign busy = (state != ST_IDLE);

  always_comb begin
    state_next     = state;
    hash_next      = hash;
    last_next      = last;
    loc_next       = loc;
    step_next      = step;
    probe_cnt_next = probe_cnt;
    clr_cnt_next   = clr_cnt;
    done_next      = 1'b0;
    slot_next      = slot;
    placed_next    = placed;
    mem_we         = 1'b0;
    mem_waddr      = loc;
    mem_wdata      = 1'b1;
    mreq.go        = 1'b0;
    // hash is zero at key start, so h*37 + c covers the first character too
    mreq.value     = VAL_W'(hash) * VAL_W'(HASH_MUL) + VAL_W'(key_char);
    mreq.modulus   = m_eff;

    case (state)
      ST_CLEAR: begin
        mem_we       = 1'b1;
        mem_waddr    = clr_cnt;
        mem_wdata    = 1'b0;
        clr_cnt_next = clr_cnt + 1'b1;
        if (clr_cnt == {SLOT_W{1'b1}}) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          mreq.go    = 1'b1;
          last_next  = last_char;
          state_next = ST_HASH;
        end
      end
      ST_HASH: begin
        if (mod_done) begin
          if (last) begin
            hash_next      = '0;
            loc_next       = mod_rem;
            step_next      = SLOT_W'(1);
            probe_cnt_next = '0;
            state_next     = ST_PROBE_RD;
          end else begin
            hash_next  = mod_rem;
            state_next = ST_IDLE;
          end
        end
      end
      ST_PROBE_RD: begin
        state_next = ST_PROBE_CHK;
      end
      ST_PROBE_CHK: begin
        if (!rd_used) begin
          mem_we      = 1'b1;
          done_next   = 1'b1;
          slot_next   = loc;
          placed_next = 1'b1;
          state_next  = ST_IDLE;
        end else if (M_W'(probe_cnt) == m_eff - 1'b1) begin
          done_next   = 1'b1;
          slot_next   = '0;
          placed_next = 1'b0;
          state_next  = ST_IDLE;
        end else begin
          // (i+1)^2 - i^2 = 2i+1: step runs through the odd numbers mod M
          loc_next       = add_mod(loc, step, m_eff);
          step_next      = add_mod(step, SLOT_W'(2), m_eff);
          probe_cnt_next = probe_cnt + 1'b1;
          state_next     = ST_PROBE_RD;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      table_size <= M_RESET;
      hash       <= '0;
      clr_cnt    <= '0;
      done       <= 1'b0;
    end else begin
      state   <= state_next;
      hash    <= hash_next;
      clr_cnt <= clr_cnt_next;
      done    <= done_next;
      if (cfg_we) begin
        table_size <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    last      <= last_next;
    loc       <= loc_next;
    step      <= step_next;
    probe_cnt <= probe_cnt_next;
    slot      <= slot_next;
    placed    <= placed_next;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_used[mem_waddr] <= mem_wdata;
    end
    rd_used <= slot_used[loc];
  end

endmodule
`default_nettype wire

FILE: hdl/shqp_checker.sv
`default_nettype none
module shqp_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          start,
  input wire logic                          busy,
  input wire logic                          done,
  input wire logic [shqp_pkg::SLOT_W-1:0]   slot,
  input wire logic                          placed
);

  // reset starts the table clearing pass
  a_clear_after_reset: assert property (@(posedge clk) rst |=> busy)
    else $error("busy low right after reset");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("item accepted but busy did not rise");

  // each result needs a new item hashed and probed first, so results never come back to back
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done high two cycles in a row");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while still busy");

  a_unplaced_slot: assert property (@(posedge clk) disable iff (rst)
    done && !placed |-> slot == '0)
    else $error("unplaced key reports nonzero slot");

endmodule

bind string_hash_quadratic_probe_insert_top shqp_checker u_shqp_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .slot   (slot),
  .placed (placed)
);
`default_nettype wire

FILE: sim/tb.sv
typedef struct packed {
  logic [shqp_pkg::SLOT_W-1:0] slot;
  logic                        placed;
} insert_result_t;

// Tracks the hash/occupancy state and the inserts still owed by the block.
class insert_tracker;
  logic [shqp_pkg::M_W-1:0]    size_reg;
  logic [shqp_pkg::SLOT_W-1:0] run_hash;
  bit                          key_start;
  bit                          used[shqp_pkg::TABLE_SLOTS];
  insert_result_t              expected_q[$];
  int                          errors;

  function new();
    size_reg  = shqp_pkg::M_RESET;
    run_hash  = '0;
    key_start = 1'b1;
    foreach (used[i]) used[i] = 1'b0;
    errors    = 0;
  endfunction

  function void set_size(logic [shqp_pkg::M_W-1:0] v);
    size_reg = v;
  endfunction

  function int modulus();
    if (size_reg < shqp_pkg::M_MIN) return int'(shqp_pkg::M_MIN);
    if (size_reg > shqp_pkg::M_MAX) return int'(shqp_pkg::M_MAX);
    return int'(size_reg);
  endfunction

  function void note_char(logic [7:0] c, logic last);
    int m;
    int h;
    int loc;
    bit found;
    insert_result_t r;
    m = modulus();
    // hash is reduced by the current modulus, so a size change mid-key is safe
    if (key_start) h = int'(c) % m;
    else h = ((int'(run_hash) % m) * shqp_pkg::HASH_MUL + int'(c)) % m;
    run_hash  = h[shqp_pkg::SLOT_W-1:0];
    key_start = last;
    if (!last) return;
    loc   = h;
    found = !used[loc];
    for (int i = 1; i < m && !found; i++) begin
      loc   = (h + i * i) % m;
      found = !used[loc];
    end
    run_hash = '0;
    if (found) begin
      used[loc] = 1'b1;
      r.slot    = loc[shqp_pkg::SLOT_W-1:0];
      r.placed  = 1'b1;
    end else begin
      r.slot   = '0;
      r.placed = 1'b0;
    end
    expected_q.push_back(r);
  endfunction

  function void check_slot(logic [shqp_pkg::SLOT_W-1:0] s, logic p);
    insert_result_t e;
    if (expected_q.size() == 0) begin
      $error("unexpected result: slot=%0d placed=%0d", s, p);
      errors++;
      return;
    end
    e = expected_q.pop_front();
    if (s !== e.slot) begin
      $error("slot mismatch: expected %0d, actual %0d", e.slot, s);
      errors++;
    end
    if (p !== e.placed) begin
      $error("placed mismatch: expected %0d, actual %0d", e.placed, p);
      errors++;
    end
  endfunction
endclass

module tb;
  logic                        clk       = 1'b0;
  logic                        rst       = 1'b1;
  logic                        start     = 1'b0;
  logic [7:0]                  key_char  = '0;
  logic                        last_char = 1'b0;
  logic                        cfg_we    = 1'b0;
  logic [shqp_pkg::M_W-1:0]    cfg_data  = '0;
  logic                        busy;
  logic                        done;
  logic [shqp_pkg::SLOT_W-1:0] slot;
  logic                        placed;

  insert_tracker keys = new();
  int            idle_pct = 0;

  // table sizes visited by the random part, extremes and non-primes included
  int size_list[19] = '{3, 5, 7, 13, 0, 1, 31, 61, 1024, 127, 2047, 11, 4, 251, 100,
                        1500, 509, 2, 1021};

  string_hash_quadratic_probe_insert_top dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .key_char  (key_char),
    .last_char (last_char),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .done      (done),
    .slot      (slot),
    .placed    (placed)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && done) keys.check_slot(slot, placed);
  end

  task automatic push_char(input logic [7:0] c, input logic last);
    start     <= 1'b1;
    key_char  <= c;
    last_char <= last;
    @(posedge clk);
    while (busy) @(posedge clk);
    keys.note_char(c, last);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
  endtask

  // only while idle; a trailing non-last char may still be hashing
  task automatic write_table_size(input logic [shqp_pkg::M_W-1:0] v);
    start <= 1'b0;
    while (keys.expected_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    while (busy) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    keys.set_size(v);
  endtask

  task automatic run_keys(input int n_items);
    int         sent;
    int         len;
    logic [7:0] key[$];
    logic [7:0] prev[$];
    sent = 0;
    while (sent < n_items) begin
      // repeated keys force collisions and long probe walks
      if (prev.size() > 0 && $urandom_range(99) < 20) begin
        key = prev;
      end else begin
        key = {};
        len = ($urandom_range(9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
        repeat (len) key.push_back(($urandom_range(29) == 0) ? 8'd0 : 8'($urandom_range(1, 255)));
      end
      for (int k = 0; k < key.size(); k++) begin
        push_char(key[k], k == key.size() - 1);
        sent++;
      end
      prev = key;
    end
    // leave a key open across the next size change now and then
    if ($urandom_range(99) < 30) push_char(8'($urandom_range(255)), 1'b0);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset size: extremes, collisions, multi-char keys
    push_char(8'h00, 1'b1);
    push_char(8'hFF, 1'b1);
    push_char(8'h00, 1'b1);
    push_char(8'h41, 1'b0);
    push_char(8'h42, 1'b0);
    push_char(8'h43, 1'b1);
    push_char(8'h41, 1'b0);
    push_char(8'h42, 1'b0);
    push_char(8'h43, 1'b1);
    push_char(8'hAA, 1'b0);
    push_char(8'h55, 1'b1);
    push_char(8'h7F, 1'b0);
    // size changes mid-key, then the two-slot table fills up
    write_table_size(shqp_pkg::M_MIN);
    push_char(8'h80, 1'b1);
    push_char(8'h03, 1'b1);
    push_char(8'h05, 1'b1);

    for (int p = 0; p < 19; p++) begin
      write_table_size(size_list[p][shqp_pkg::M_W-1:0]);
      idle_pct = (p < 6) ? 23 : (p < 12) ? 54 : 0;
      run_keys(keys.modulus() >= 251 ? 60 : 85);
    end

    start <= 1'b0;
    while (keys.expected_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (keys.errors == 0 && keys.expected_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #30000000;
    $display("tb: failure");
    $finish;
  end
endmodule
